/* rtl/fsps_pkg.sv */
`default_nettype none
package fsps_pkg;

  localparam int TOTAL_BITS = 16;
  localparam int SUM_BITS = TOTAL_BITS + 1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  localparam int CFG_COUNT = 8;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int PADDR_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_INT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LLONG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PTRDIFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTMAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER = 3'd7;

  typedef logic [CFG_COUNT-1:0][CFG_W-1:0] cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = {5'd4, 5'd8, 5'd8, 5'd4, 5'd4, 5'd8, 5'd4, 5'd4};

  localparam logic [2:0] PH_NORMAL  = 3'd0;
  localparam logic [2:0] PH_SPEC    = 3'd1;
  localparam logic [2:0] PH_WIDTH   = 3'd2;
  localparam logic [2:0] PH_PREC    = 3'd3;
  localparam logic [2:0] PH_AFTER_H = 3'd4;
  localparam logic [2:0] PH_AFTER_L = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_H     = "h";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_Z     = "z";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_J     = "j";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_C     = "c";
  localparam logic [7:0] CH_F     = "f";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_UE    = "E";
  localparam logic [7:0] CH_G     = "g";
  localparam logic [7:0] CH_UG    = "G";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_P     = "p";
  localparam logic [7:0] CH_N     = "n";

  typedef struct packed {
    logic [2:0]           phase_next;
    logic                 add_en;
    logic [CFG_IDX_W-1:0] add_sel;
  } step_ctl_t;

endpackage
`default_nettype wire

/* rtl/format_string_arg_size_scanner.sv */
// A terminator beat passes through the input register and then the result register, whose total drives the output.
// Throughput: one character per cycle while a terminator beat finds room in the result register;
// the scan state and one saturating add form the loop between the input register and the state/result registers.
// Output stalls back up through the input register without dropping beats.
// Reset (synchronous) clears the scan state, total and flags and loads default sizes.
`default_nettype none
module format_string_arg_size_scanner (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   ch,
  input  wire logic                         end_of_string,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [15:0]                       total_bytes,
  output logic                              saturated,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fsps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import fsps_pkg::*;

  cfg_regs_t cfg;

  logic                  in_valid_r;
  logic [7:0]            ch_r;
  logic                  eos_r;
  logic [2:0]            phase;
  logic [TOTAL_BITS-1:0] byte_total;
  logic                  overflow_seen;

  step_ctl_t             ctl;
  logic                  advance;
  logic [SUM_BITS-1:0]   sum;
  logic                  clamp;
  logic [TOTAL_BITS-1:0] total_next;

  fsps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fsps_decode u_decode (
    .phase         (phase),
    .ch            (ch_r),
    .end_of_string (eos_r),
    .ctl           (ctl)
  );

  // only a terminator beat needs room in the result register
  assign advance = in_valid_r && (!eos_r || !out_valid || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign sum = {1'b0, byte_total} + SUM_BITS'(cfg[ctl.add_sel]);
  assign clamp = ctl.add_en && sum[TOTAL_BITS];
  always_comb begin
    if (!ctl.add_en) total_next = byte_total;
    else if (clamp) total_next = TOTAL_MAX;
    else total_next = sum[TOTAL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= ch;
      eos_r <= end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      byte_total <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      phase <= ctl.phase_next;
      if (eos_r) begin
        byte_total <= '0;
        overflow_seen <= 1'b0;
      end else begin
        byte_total <= total_next;
        overflow_seen <= overflow_seen | clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && eos_r) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eos_r) begin
      total_bytes <= 16'(total_next);
      saturated <= overflow_seen | clamp;
    end
  end

`ifndef SYNTHESIS
  a_sat_total: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> byte_total == TOTAL_MAX)
    else $error("overflow flag set but total not at limit");

  a_sat_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> total_bytes == 16'(TOTAL_MAX))
    else $error("saturated result without clamped total");

  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    advance && eos_r |=> byte_total == '0 && !overflow_seen && phase == PH_NORMAL)
    else $error("scan state not cleared after terminator");

  a_eos_out: assert property (@(posedge clk) disable iff (rst)
    advance && eos_r |=> out_valid)
    else $error("terminator beat produced no result");

  a_eos_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid_r && eos_r && out_valid && !out_ready |=> in_valid_r && eos_r)
    else $error("stalled terminator beat lost");
`endif

endmodule
`default_nettype wire

/* rtl/fsps_cfg_regs.sv */
`default_nettype none
module fsps_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fsps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output fsps_pkg::cfg_regs_t              cfg
);
  import fsps_pkg::*;

  logic [CFG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = {{(32-CFG_W){1'b0}}, cfg[reg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      cfg[reg_idx] <= pwdata[CFG_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/fsps_decode.sv */
`default_nettype none
module fsps_decode (
  input  wire logic [2:0]         phase,
  input  wire logic [7:0]         ch,
  input  wire logic               end_of_string,
  output fsps_pkg::step_ctl_t     ctl
);
  import fsps_pkg::*;

  logic is_digit;
  logic is_flag;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_flag = (ch == CH_MINUS) || (ch == CH_PLUS) || (ch == CH_SPACE) ||
                   (ch == CH_HASH) || (ch == CH_ZERO);

  // character that closes flags/width/precision
  function automatic step_ctl_t conv(input logic [7:0] c);
    step_ctl_t r;
    r.phase_next = PH_NORMAL;
    r.add_en = 1'b0;
    r.add_sel = CFG_INT;
    case (c)
      CH_H: begin
        r.add_en = 1'b1; r.add_sel = CFG_INT; r.phase_next = PH_AFTER_H;
      end
      CH_L: r.phase_next = PH_AFTER_L;
      CH_Z: begin
        r.add_en = 1'b1; r.add_sel = CFG_SIZE; r.phase_next = PH_SKIP;
      end
      CH_T: begin
        r.add_en = 1'b1; r.add_sel = CFG_PTRDIFF; r.phase_next = PH_SKIP;
      end
      CH_J: begin
        r.add_en = 1'b1; r.add_sel = CFG_INTMAX; r.phase_next = PH_SKIP;
      end
      CH_D, CH_I, CH_O, CH_U, CH_X, CH_UX, CH_C: begin
        r.add_en = 1'b1; r.add_sel = CFG_INT;
      end
      CH_F, CH_UF, CH_E, CH_UE, CH_G, CH_UG: begin
        r.add_en = 1'b1; r.add_sel = CFG_DOUBLE;
      end
      CH_S, CH_P, CH_N: begin
        r.add_en = 1'b1; r.add_sel = CFG_POINTER;
      end
      default: r.add_en = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    ctl.phase_next = phase;
    ctl.add_en = 1'b0;
    ctl.add_sel = CFG_INT;
    if (end_of_string) begin
      // a dangling single l still counts
      ctl.phase_next = PH_NORMAL;
      ctl.add_en = (phase == PH_AFTER_L);
      ctl.add_sel = CFG_LONG;
    end else begin
      case (phase)
        PH_NORMAL: begin
          if (ch == CH_PCT) ctl.phase_next = PH_SPEC;
        end
        PH_SPEC: begin
          if (is_flag) ctl.phase_next = PH_SPEC;
          else if (is_digit) ctl.phase_next = PH_WIDTH;
          else if (ch == CH_DOT) ctl.phase_next = PH_PREC;
          else ctl = conv(ch);
        end
        PH_WIDTH: begin
          if (is_digit) ctl.phase_next = PH_WIDTH;
          else if (ch == CH_DOT) ctl.phase_next = PH_PREC;
          else ctl = conv(ch);
        end
        PH_PREC: begin
          if (!is_digit) ctl = conv(ch);
        end
        PH_AFTER_H: begin
          ctl.phase_next = (ch == CH_H) ? PH_SKIP : PH_NORMAL;
        end
        PH_AFTER_L: begin
          ctl.add_en = 1'b1;
          if (ch == CH_L) begin
            ctl.add_sel = CFG_LLONG;
            ctl.phase_next = PH_SKIP;
          end else begin
            ctl.add_sel = CFG_LONG;
            ctl.phase_next = PH_NORMAL;
          end
        end
        default: ctl.phase_next = PH_NORMAL;
      endcase
    end
  end

endmodule
`default_nettype wire
